// ===== rtl/oxygen_sensor_frame_parser_top_assert.svh =====
// Assertion macros used by the checker file of the frame parser.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef OXYGEN_SENSOR_FRAME_PARSER_TOP_ASSERT_SVH
`define OXYGEN_SENSOR_FRAME_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define OFP_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define OFP_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define OFP_ASSERT_RST(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/ofp_pkg.sv =====
`default_nettype none

package ofp_pkg;

  localparam int unsigned CNT_W             = 4;
  localparam int unsigned PAYLOAD_BYTES_DEF = 8;

  localparam logic [7:0] HDR_BYTE = 8'h16;
  localparam logic [7:0] LEN_BYTE = 8'h09;
  localparam logic [7:0] CMD_BYTE = 8'h01;
  localparam logic [7:0] SUM_SEED = 8'h20;

  localparam logic [1:0] ST_GOOD   = 2'd0;
  localparam logic [1:0] ST_BADSUM = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;
  localparam logic [1:0] ST_BADCMD = 2'd3;

  localparam int unsigned OQ_DEPTH = 3;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [15:0] o2_tenths;
    logic        value_valid;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/ofp_parse.sv =====
`default_nettype none

module ofp_parse
  import ofp_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_vld,
  input  wire logic [7:0] item_byte,
  output logic            busy,
  output logic            res_vld,
  output res_t            res
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_COMMAND = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;

  localparam logic [CNT_W:0] LAST_CNT = (CNT_W + 1)'(PAYLOAD_BYTES);

  logic             vld_r;
  logic [7:0]       byte_r;
  logic [2:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [15:0]      pend_r, pend_nxt;
  logic [15:0]      stored_r, stored_nxt;
  logic             stv_r, stv_nxt;
  logic [CNT_W:0]   cnt_inc;
  logic [7:0]       chk;
  logic [1:0]       status;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    pend_nxt   = pend_r;
    stored_nxt = stored_r;
    stv_nxt    = stv_r;
    res_vld    = 1'b0;
    status     = ST_GOOD;
    cnt_inc    = {1'b0, cnt_r} + (CNT_W + 1)'(1);
    chk        = byte_r + sum_r + SUM_SEED;
    if (vld_r) begin
      unique case (phase_r)
        PH_LENGTH: begin
          if (byte_r != LEN_BYTE) begin
            phase_nxt = PH_HEADER;
            res_vld   = 1'b1;
            status    = ST_BADLEN;
          end else begin
            phase_nxt = PH_COMMAND;
          end
        end
        PH_COMMAND: begin
          if (byte_r != CMD_BYTE) begin
            phase_nxt = PH_HEADER;
            res_vld   = 1'b1;
            status    = ST_BADCMD;
          end else begin
            phase_nxt = PH_PAYLOAD;
            cnt_nxt   = '0;
            sum_nxt   = '0;
            pend_nxt  = '0;
          end
        end
        PH_PAYLOAD: begin
          sum_nxt = sum_r + byte_r;
          if (cnt_r == '0) begin
            pend_nxt = {pend_r[15:8], byte_r};
          end else if (cnt_r == CNT_W'(1)) begin
            pend_nxt = {byte_r, pend_r[7:0]};
          end
          cnt_nxt = cnt_inc[CNT_W-1:0];
          if (cnt_inc >= LAST_CNT) begin
            phase_nxt = PH_CHECK;
            cnt_nxt   = '0;
          end
        end
        PH_CHECK: begin
          stored_nxt = pend_r;
          stv_nxt    = 1'b1;
          phase_nxt  = PH_HEADER;
          cnt_nxt    = '0;
          res_vld    = 1'b1;
          status     = (chk == 8'd0) ? ST_GOOD : ST_BADSUM;
        end
        default: begin
          phase_nxt = (byte_r == HDR_BYTE) ? PH_LENGTH : PH_HEADER;
        end
      endcase
    end
  end

  always_comb begin
    res.frame_status = status;
    res.o2_tenths    = stored_nxt;
    res.value_valid  = stv_nxt;
  end

  assign busy = vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      phase_r  <= PH_HEADER;
      cnt_r    <= '0;
      stored_r <= '0;
      stv_r    <= 1'b0;
    end else begin
      vld_r    <= item_vld;
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      stored_r <= stored_nxt;
      stv_r    <= stv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_vld) begin
      byte_r <= item_byte;
    end
    sum_r  <= sum_nxt;
    pend_r <= pend_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/ofp_oq.sv =====
`default_nettype none

module ofp_oq
  import ofp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_vld,
  input  wire res_t       wr_data,
  input  wire logic       rd_take,
  output logic            rd_vld,
  output res_t            rd_data,
  output logic [OQ_CW-1:0] count
);

  localparam logic [OQ_AW-1:0] LAST_IDX = OQ_AW'(OQ_DEPTH - 1);

  res_t             mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CW-1:0] cnt_r;

  assign rd_vld  = (cnt_r != '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign count   = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_vld) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + OQ_AW'(1);
      end
      if (rd_take) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + OQ_AW'(1);
      end
      if (wr_vld && !rd_take) begin
        cnt_r <= cnt_r + OQ_CW'(1);
      end else if (!wr_vld && rd_take) begin
        cnt_r <= cnt_r - OQ_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_vld) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/oxygen_sensor_frame_parser_top.sv =====
// Channel   Direction  Ports
// in_*      receive    in_valid, in_stall, in_rx_byte
// out_*     send       out_valid, out_stall, out_frame_status, out_o2_tenths, out_value_valid
//
// One item is taken per cycle while in_stall is low; an item that ends or breaks a frame yields a result.
// Each item is registered, parsed by one step of the frame state logic, and any result
// is written into a three-entry output queue that parts the two channels.
// Reset is synchronous and active low; the parser returns to hunting for a header.
// in_stall rises only when the queue and the parse stage together could overflow.
`default_nettype none

module oxygen_sensor_frame_parser_top
  import ofp_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_frame_status,
  output logic [15:0]      out_o2_tenths,
  output logic             out_value_valid
);

  logic             busy;
  logic             res_vld;
  res_t             res;
  res_t             head;
  logic [OQ_CW-1:0] q_cnt;
  logic [OQ_CW:0]   occ;
  logic             in_take;

  assign occ      = {1'b0, q_cnt} + {{OQ_CW{1'b0}}, busy};
  assign in_stall = (occ >= (OQ_CW + 1)'(OQ_DEPTH));
  assign in_take  = in_valid && !in_stall;

  ofp_parse #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (in_take),
    .item_byte(in_rx_byte),
    .busy     (busy),
    .res_vld  (res_vld),
    .res      (res)
  );

  ofp_oq u_oq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_vld (res_vld),
    .wr_data(res),
    .rd_take(out_valid && !out_stall),
    .rd_vld (out_valid),
    .rd_data(head),
    .count  (q_cnt)
  );

  assign out_frame_status = head.frame_status;
  assign out_o2_tenths    = head.o2_tenths;
  assign out_value_valid  = head.value_valid;

endmodule

`default_nettype wire

// ===== rtl/ofp_chk.sv =====
`default_nettype none
`include "oxygen_sensor_frame_parser_top_assert.svh"

module ofp_chk
  import ofp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_frame_status,
  input wire logic       out_value_valid
);

  logic sum_res;

  assign sum_res = out_valid && (out_frame_status == ST_GOOD || out_frame_status == ST_BADSUM);

  // A frame that reached its checksum byte has always stored a value.
  `OFP_ASSERT_IMP(a_sum_has_value, sum_res, out_value_valid, "checksum result without value")

  // Reset empties the output queue.
  `OFP_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result visible right after reset")

  // With nothing waiting at the output, the input cannot be stalled in the next cycle.
  `OFP_ASSERT_NXT(a_no_false_stall, !out_valid, !in_stall, "input stalled with an empty output")

  // A stalled result is held.
  `OFP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "stalled item dropped")

endmodule

bind oxygen_sensor_frame_parser_top ofp_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_frame_status(out_frame_status),
  .out_value_valid (out_value_valid)
);

`default_nettype wire
